[design/assert_macros.svh]
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_CLK_RST(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

[design/sfc_pkg.sv]
package sfc_pkg;

   localparam int PlaneCount = 6;
   localparam int PlaneIdxW  = 3;
   localparam int CoordW     = 28;
   localparam int DeltaW     = 29;
   localparam int NormW      = 12;
   localparam int DotW       = 44;
   localparam int FacW       = 17;
   localparam int QuotW      = 17;
   localparam int ProdW      = DeltaW + FacW + 1;
   localparam int SumW       = CoordW + 2;
   localparam int CountW     = 5;
   localparam int DivSteps   = 16;
   localparam logic [FacW-1:0] FacOne = 17'd65536;

   typedef struct packed {
      logic signed [CoordW-1:0] start_x;
      logic signed [CoordW-1:0] start_y;
      logic signed [CoordW-1:0] start_z;
      logic signed [CoordW-1:0] end_x;
      logic signed [CoordW-1:0] end_y;
      logic signed [CoordW-1:0] end_z;
   } req_payload_type;

   typedef struct packed {
      logic                     visible;
      logic signed [CoordW-1:0] clip_start_x;
      logic signed [CoordW-1:0] clip_start_y;
      logic signed [CoordW-1:0] clip_start_z;
      logic signed [CoordW-1:0] clip_end_x;
      logic signed [CoordW-1:0] clip_end_y;
      logic signed [CoordW-1:0] clip_end_z;
      logic [FacW-1:0]          span_factor;
   } rsp_payload_type;

   typedef struct packed {
      logic                 load;
      logic                 dot;
      logic                 eval;
      logic                 div_start;
      logic                 div_step;
      logic                 merge;
      logic                 use_f1;
      logic                 fin_p1;
      logic                 fin_p2;
      logic [PlaneIdxW-1:0] plane;
      logic [1:0]           axis;
   } sfc_cmd_type;

   typedef struct packed {
      logic need_div;
      logic reject;
      logic div_done;
   } sfc_sts_type;

endpackage

[design/segment_frustum_clipper_top.sv]
// Each plane passes through a dot-product state and an evaluation state, and a
// plane that needs it also through the serial division and a merge; unless the
// segment is rejected, the clipped end points then follow axis by axis, and
// the response is held in an output state. One segment is taken at a time.
// Reset is synchronous and active high; it returns the controller to idle
// and clears every plane register to zero.
`include "assert_macros.svh"
module segment_frustum_clipper_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sfc_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output sfc_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write,
   input  logic [2:0]               csr_index,
   input  logic [63:0]              csr_data
);
   import sfc_pkg::*;

   logic [63:0] plane_ff [PlaneCount];
   sfc_cmd_type cmd;
   sfc_sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PlaneCount; i++) plane_ff[i] <= '0;
      end else if (csr_write && csr_index < 3'(PlaneCount)) begin
         plane_ff[csr_index] <= csr_data;
      end
   end

   sfc_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   sfc_datapath u_dp (
      .clock, .cmd, .sts, .req_in(req_payload),
      .plane_in(plane_ff[cmd.plane]), .rsp_out(rsp_payload)
   );

   `ASSERT_CLK(a_no_overlap, clock, reset, !(req_ready && rsp_valid))
   `ASSERT_CLK(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_CLK_RST(a_reset_idle, clock, $past(reset) |-> !rsp_valid)

endmodule

[design/sfc_datapath.sv]
module sfc_datapath (
   input  logic                     clock,
   input  sfc_pkg::sfc_cmd_type     cmd,
   output sfc_pkg::sfc_sts_type     sts,
   input  sfc_pkg::req_payload_type req_in,
   input  logic [63:0]              plane_in,
   output sfc_pkg::rsp_payload_type rsp_out
);
   import sfc_pkg::*;

   logic signed [CoordW-1:0] s_ff [3];
   logic signed [CoordW-1:0] e_ff [3];
   logic signed [DeltaW-1:0] dp_ff [3];
   logic signed [NormW-1:0]  n [3];
   logic signed [CoordW-1:0] d;
   logic signed [DotW-1:0]   div_ff, div_in, t_ff, t_in;
   logic [FacW-1:0]          f1_ff, f2_ff;
   logic                     rej_ff, rej_in, neg_ff, need_in;
   logic [DotW-1:0]          den_ff, rem_ff, abs_t;
   logic [DotW:0]            trial;
   logic [QuotW-1:0]         q_ff;
   logic [CountW-1:0]        cnt_ff;
   logic [FacW-1:0]          fac;
   logic signed [ProdW-1:0]  prod_ff, prod_in;
   logic signed [SumW-1:0]   sum;
   logic signed [CoordW-1:0] sat, p1_ff [3], p2_ff [3];
   logic signed [FacW:0]     mul_f;

   assign n[0] = plane_in[11:0];
   assign n[1] = plane_in[23:12];
   assign n[2] = plane_in[35:24];
   assign d    = plane_in[63:36];

   always_comb begin
      div_in = DotW'(n[0] * dp_ff[0]) + DotW'(n[1] * dp_ff[1]) + DotW'(n[2] * dp_ff[2]);
      t_in   = -(DotW'(n[0] * s_ff[0]) + DotW'(n[1] * s_ff[1]) + DotW'(n[2] * s_ff[2])
                 + (DotW'(d) <<< 10));
   end

   always_comb begin
      rej_in  = rej_ff;
      need_in = 1'b0;
      if (div_ff > 0) begin
         if (t_ff >= div_ff) rej_in = 1'b1;
         else if (t_ff > 0) need_in = 1'b1;
      end else if (div_ff < 0) begin
         if (t_ff > 0) rej_in = 1'b1;
         else if (t_ff > div_ff) need_in = 1'b1;
      end
   end

   // Long division, one quotient bit per cycle; the remainder starts at |t|,
   // which is always below the divisor.
   assign abs_t = t_ff[DotW-1] ? DotW'(-t_ff) : DotW'(t_ff);
   assign trial = {rem_ff, 1'b0} - {1'b0, den_ff};
   assign fac   = (q_ff > FacOne) ? FacOne : q_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         s_ff[0] <= req_in.start_x; s_ff[1] <= req_in.start_y; s_ff[2] <= req_in.start_z;
         e_ff[0] <= req_in.end_x;   e_ff[1] <= req_in.end_y;   e_ff[2] <= req_in.end_z;
         dp_ff[0] <= DeltaW'(req_in.end_x) - DeltaW'(req_in.start_x);
         dp_ff[1] <= DeltaW'(req_in.end_y) - DeltaW'(req_in.start_y);
         dp_ff[2] <= DeltaW'(req_in.end_z) - DeltaW'(req_in.start_z);
         f1_ff  <= '0;
         f2_ff  <= FacOne;
         rej_ff <= 1'b0;
      end
      if (cmd.dot) begin
         div_ff <= div_in;
         t_ff   <= t_in;
      end
      if (cmd.eval) rej_ff <= rej_in;
      if (cmd.div_start) begin
         neg_ff <= div_ff[DotW-1];
         den_ff <= div_ff[DotW-1] ? DotW'(-div_ff) : DotW'(div_ff);
         rem_ff <= abs_t;
         q_ff   <= '0;
         cnt_ff <= CountW'(DivSteps);
      end
      if (cmd.div_step) begin
         if (!trial[DotW]) begin
            rem_ff <= trial[DotW-1:0];
            q_ff   <= {q_ff[QuotW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DotW-2:0], 1'b0};
            q_ff   <= {q_ff[QuotW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.merge) begin
         if (!neg_ff && fac > f1_ff) begin
            f1_ff <= fac;
            if (fac > f2_ff) rej_ff <= 1'b1;
         end else if (neg_ff && fac < f2_ff) begin
            f2_ff <= fac;
            if (f1_ff > fac) rej_ff <= 1'b1;
         end
      end
      prod_ff <= prod_in;
      if (cmd.fin_p1) p1_ff[cmd.axis] <= sat;
      if (cmd.fin_p2) p2_ff[cmd.axis] <= sat;
   end

   assign mul_f   = cmd.use_f1 ? $signed({1'b0, f1_ff}) : $signed({1'b0, f2_ff - f1_ff});
   assign prod_in = dp_ff[cmd.axis] * mul_f;

   always_comb begin
      sum = (cmd.fin_p1 ? SumW'(s_ff[cmd.axis]) : SumW'(p1_ff[cmd.axis]))
            + SumW'(prod_ff >>> 16);
      if (sum > SumW'(134217727))       sat = CoordW'(134217727);
      else if (sum < -SumW'(134217728)) sat = CoordW'(-134217728);
      else                              sat = CoordW'(sum);
   end

   assign sts.need_div = need_in;
   assign sts.reject   = rej_ff;
   assign sts.div_done = (cnt_ff == '0);

   always_comb begin
      rsp_out.visible     = !rej_ff;
      rsp_out.span_factor = rej_ff ? FacOne : f2_ff - f1_ff;
      rsp_out.clip_start_x = rej_ff ? s_ff[0] : p1_ff[0];
      rsp_out.clip_start_y = rej_ff ? s_ff[1] : p1_ff[1];
      rsp_out.clip_start_z = rej_ff ? s_ff[2] : p1_ff[2];
      rsp_out.clip_end_x   = rej_ff ? e_ff[0] : p2_ff[0];
      rsp_out.clip_end_y   = rej_ff ? e_ff[1] : p2_ff[1];
      rsp_out.clip_end_z   = rej_ff ? e_ff[2] : p2_ff[2];
   end

endmodule

[design/sfc_control.sv]
module sfc_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sfc_pkg::sfc_sts_type sts,
   output sfc_pkg::sfc_cmd_type cmd
);
   import sfc_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_DOT   = 8'b00000010,
      S_EVAL  = 8'b00000100,
      S_DIV   = 8'b00001000,
      S_MERGE = 8'b00010000,
      S_MUL1  = 8'b00100000,
      S_MUL2  = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   state_type            state_ff, state_in;
   logic [PlaneIdxW-1:0] plane_ff, plane_in;
   logic [1:0]           axis_ff, axis_in;
   logic                 ph_ff, ph_in;
   logic                 last_plane;

   assign last_plane = (plane_ff == PlaneIdxW'(PlaneCount - 1));
   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      plane_in = plane_ff;
      axis_in  = axis_ff;
      ph_in    = 1'b0;
      cmd      = '0;
      cmd.plane = plane_ff;
      cmd.axis  = axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               plane_in = '0;
               state_in = S_DOT;
            end
         end
         S_DOT: begin
            cmd.dot  = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.reject) begin
               state_in = S_OUT;
            end else if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else if (last_plane) begin
               axis_in  = '0;
               state_in = S_MUL1;
            end else begin
               plane_in = plane_ff + 1'b1;
               state_in = S_DOT;
            end
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_MERGE;
            else cmd.div_step = 1'b1;
         end
         S_MERGE: begin
            cmd.merge = 1'b1;
            if (last_plane) begin
               axis_in  = '0;
               state_in = S_MUL1;
            end else begin
               plane_in = plane_ff + 1'b1;
               state_in = S_DOT;
            end
         end
         S_MUL1: begin
            ph_in = !ph_ff;
            cmd.use_f1 = 1'b1;
            cmd.fin_p1 = ph_ff;
            if (sts.reject) state_in = S_OUT;
            else if (ph_ff) begin
               if (axis_ff == 2'd2) begin
                  axis_in  = '0;
                  state_in = S_MUL2;
               end else axis_in = axis_ff + 1'b1;
            end
         end
         S_MUL2: begin
            ph_in = !ph_ff;
            cmd.fin_p2 = ph_ff;
            if (ph_ff) begin
               if (axis_ff == 2'd2) state_in = S_OUT;
               else axis_in = axis_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         plane_ff <= '0;
         axis_ff  <= '0;
         ph_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         plane_ff <= plane_in;
         axis_ff  <= axis_in;
         ph_ff    <= ph_in;
      end
   end

endmodule
